[src/lmtc_pkg.sv]
// Shared types and timing constants for the LCD mode and line timing controller.
package lmtc_pkg;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_WR_STAT  = 3'd1,
    OP_WR_CTRL  = 3'd2,
    OP_WR_LYC   = 3'd3,
    OP_RD_STAT  = 3'd4,
    OP_RD_LINE  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_t;

  // Line position bounds, in quarter-clock units (accumulator is 9 bits wide before wrap)
  localparam logic [8:0] OamEnd     = 9'(204 / 4);
  localparam logic [8:0] DrawEnd    = 9'(284 / 4);
  localparam logic [8:0] LineCycles = 9'(456 / 4);

  localparam logic [7:0] FirstVblankLine = 8'd144;
  localparam logic [7:0] LastLine        = 8'd153;

  // Bit positions inside the stored status enables (status byte bits 7..3)
  localparam int EnMatchBit  = 3;
  localparam int EnOamBit    = 2;
  localparam int EnVblankBit = 1;
  localparam int EnHblankBit = 0;

  // Control byte bit that turns the display on
  localparam int DisplayBit = 7;

endpackage

[src/lcd_mode_timing_controller.sv]
// LCD mode and scan line timing controller: bus accesses in, one result per access out.
// The result of a transfer is in the output register at the next edge.
// Throughput: one transfer per cycle while the input is not stalled; all state updates in the same cycle as acceptance,
//   so back-to-back ticks and register accesses chain directly through the state registers.
// Input stalls only while a result sits in the output register and the output is stalled.
// Reset (rst_n low, synchronous): line 0, mode hblank, accumulator 0, display on,
//   compare value 0, status enables 0, match flag 0, output register empty.
module lcd_mode_timing_controller (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_op,
  input  logic [5:0] in_elapsed,
  input  logic [7:0] in_wdata,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_rdata,
  output logic       out_stat_irq,
  output logic       out_vblank_irq,
  output logic       out_render_req,
  output logic [7:0] out_cur_line,
  output logic [1:0] out_cur_mode
);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [7:0]          cycle_acc_r, cycle_acc_nxt;
  logic [7:0]          scan_line_r, scan_line_nxt;
  lmtc_pkg::mode_t     mode_r, mode_nxt;
  logic                display_on_r, display_on_nxt;
  logic [7:0]          line_compare_r, line_compare_nxt;
  logic [4:0]          status_upper_r, status_upper_nxt;
  logic                match_flag_r, match_flag_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_rdata_r, rdata_nxt;
  logic                out_stat_r, stat_nxt;
  logic                out_vbl_r, vbl_nxt;
  logic                out_rnd_r, rnd_nxt;
  logic [7:0]          out_line_r;
  lmtc_pkg::mode_t     out_mode_r;

  logic                in_xfer;
  logic                match_chk;
  logic [8:0]          acc_sum;
  logic [8:0]          acc_wrap;
  logic [7:0]          line_inc;

  // A new transfer is taken whenever the output register is free or drains this cycle.
  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  assign acc_sum  = {1'b0, cycle_acc_r} + {3'b000, in_elapsed};
  assign acc_wrap = acc_sum - lmtc_pkg::LineCycles;
  assign line_inc = scan_line_r + 8'd1;

  // ---------------------------------------------------------------------------
  // Next state and result for one access
  // ---------------------------------------------------------------------------
  always_comb begin
    cycle_acc_nxt    = cycle_acc_r;
    scan_line_nxt    = scan_line_r;
    mode_nxt         = mode_r;
    display_on_nxt   = display_on_r;
    line_compare_nxt = line_compare_r;
    status_upper_nxt = status_upper_r;
    match_flag_nxt   = match_flag_r;
    rdata_nxt        = 8'd0;
    stat_nxt         = 1'b0;
    vbl_nxt          = 1'b0;
    rnd_nxt          = 1'b0;
    match_chk        = 1'b0;

    unique case (lmtc_pkg::op_t'(in_op))
      lmtc_pkg::OP_TICK: begin
        if (display_on_r) begin
          if (scan_line_r >= lmtc_pkg::FirstVblankLine) begin
            // vblank lines: enter mode 1 once, then advance lines on whole line periods
            if (mode_r != lmtc_pkg::MODE_VBLANK) begin
              stat_nxt = status_upper_r[lmtc_pkg::EnVblankBit];
              vbl_nxt  = 1'b1;
              mode_nxt = lmtc_pkg::MODE_VBLANK;
            end
            if (acc_sum >= lmtc_pkg::LineCycles) begin
              cycle_acc_nxt = acc_wrap[7:0];
              scan_line_nxt = (line_inc > lmtc_pkg::LastLine) ? 8'd0 : line_inc;
              match_chk     = 1'b1;
            end else begin
              cycle_acc_nxt = acc_sum[7:0];
            end
          end else if (acc_sum < lmtc_pkg::OamEnd) begin
            cycle_acc_nxt = acc_sum[7:0];
            if (mode_r != lmtc_pkg::MODE_OAM) begin
              stat_nxt = status_upper_r[lmtc_pkg::EnOamBit];
              mode_nxt = lmtc_pkg::MODE_OAM;
            end
          end else if (acc_sum < lmtc_pkg::DrawEnd) begin
            cycle_acc_nxt = acc_sum[7:0];
            if (mode_r != lmtc_pkg::MODE_DRAW) begin
              mode_nxt = lmtc_pkg::MODE_DRAW;
              rnd_nxt  = 1'b1;
            end
          end else if (acc_sum < lmtc_pkg::LineCycles) begin
            cycle_acc_nxt = acc_sum[7:0];
            if (mode_r != lmtc_pkg::MODE_HBLANK) begin
              stat_nxt = status_upper_r[lmtc_pkg::EnHblankBit];
              mode_nxt = lmtc_pkg::MODE_HBLANK;
            end
          end else begin
            // end of a visible line; the next line starts in hblank until the next tick
            cycle_acc_nxt = acc_wrap[7:0];
            scan_line_nxt = line_inc;
            mode_nxt      = lmtc_pkg::MODE_HBLANK;
            match_chk     = 1'b1;
          end
        end
      end
      lmtc_pkg::OP_WR_STAT: begin
        status_upper_nxt = in_wdata[7:3];
      end
      lmtc_pkg::OP_WR_CTRL: begin
        display_on_nxt = in_wdata[lmtc_pkg::DisplayBit];
        if (!in_wdata[lmtc_pkg::DisplayBit]) begin
          mode_nxt      = lmtc_pkg::MODE_VBLANK;
          scan_line_nxt = 8'd0;
          cycle_acc_nxt = 8'd0;
        end else begin
          match_chk = 1'b1;
        end
      end
      lmtc_pkg::OP_WR_LYC: begin
        line_compare_nxt = in_wdata;
        match_chk        = display_on_r;
      end
      lmtc_pkg::OP_RD_STAT: begin
        rdata_nxt = {status_upper_r, match_flag_r, mode_r};
      end
      lmtc_pkg::OP_RD_LINE: begin
        rdata_nxt = scan_line_r;
      end
      default: begin
      end
    endcase

    // line compare against the updated line and compare value
    if (match_chk) begin
      match_flag_nxt = (scan_line_nxt == line_compare_nxt);
      if (match_flag_nxt && status_upper_r[lmtc_pkg::EnMatchBit]) begin
        stat_nxt = 1'b1;
      end
    end
  end

  // Output register holds while stalled, empties when taken with nothing new.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_acc_r    <= 8'd0;
      scan_line_r    <= 8'd0;
      mode_r         <= lmtc_pkg::MODE_HBLANK;
      display_on_r   <= 1'b1;
      line_compare_r <= 8'd0;
      status_upper_r <= 5'd0;
      match_flag_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        cycle_acc_r    <= cycle_acc_nxt;
        scan_line_r    <= scan_line_nxt;
        mode_r         <= mode_nxt;
        display_on_r   <= display_on_nxt;
        line_compare_r <= line_compare_nxt;
        status_upper_r <= status_upper_nxt;
        match_flag_r   <= match_flag_nxt;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_rdata_r <= rdata_nxt;
      out_stat_r  <= stat_nxt;
      out_vbl_r   <= vbl_nxt;
      out_rnd_r   <= rnd_nxt;
      out_line_r  <= scan_line_nxt;
      out_mode_r  <= mode_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rdata      = out_rdata_r;
  assign out_stat_irq   = out_stat_r;
  assign out_vblank_irq = out_vbl_r;
  assign out_render_req = out_rnd_r;
  assign out_cur_line   = out_line_r;
  assign out_cur_mode   = out_mode_r;

`ifndef ASSERT_OFF
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_line_r <= lmtc_pkg::LastLine)
    else $error("scan line out of range");

  a_render_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rnd_r |-> out_mode_r == lmtc_pkg::MODE_DRAW)
    else $error("render request outside draw mode");

  a_vblank_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_vbl_r |-> out_mode_r == lmtc_pkg::MODE_VBLANK)
    else $error("vblank interrupt without vblank mode");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(scan_line_r) && $stable(cycle_acc_r))
    else $error("timing state changed while output stalled");
`endif

endmodule

[bench/lmtc_checker.sv]
// Checker for the LCD timing controller: tracks both channels, predicts each result, compares.
module lmtc_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] in_op,
  input  logic [5:0] in_elapsed,
  input  logic [7:0] in_wdata,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_rdata,
  input  logic       out_stat_irq,
  input  logic       out_vblank_irq,
  input  logic       out_render_req,
  input  logic [7:0] out_cur_line,
  input  logic [1:0] out_cur_mode,
  output int         fail_count,
  output int         pending,
  output int         n_checked,
  output int         n_vblank,
  output int         n_render,
  output int         n_stat
);

  typedef struct packed {
    logic [7:0]      rdata;
    logic            stat_irq;
    logic            vblank_irq;
    logic            render_req;
    logic [7:0]      cur_line;
    lmtc_pkg::mode_t cur_mode;
  } lcd_result_t;

  // predicted controller state
  logic [7:0]      acc_q;
  logic [7:0]      line_q;
  lmtc_pkg::mode_t mode_q;
  logic            disp_on_q;
  logic [7:0]      lyc_q;
  logic [4:0]      stat_en_q;
  logic            match_q;

  lcd_result_t pending_lcd_results[$];
  lcd_result_t want;

  // line compare: updates the match flag, returns the status interrupt it raises
  function automatic logic refresh_match();
    match_q = (line_q == lyc_q);
    return match_q && stat_en_q[lmtc_pkg::EnMatchBit];
  endfunction

  function automatic lcd_result_t lcd_timing_step(input logic [2:0] op, input logic [5:0] el,
                                                  input logic [7:0] wd);
    logic [8:0]  acc;
    lcd_result_t r;
    r = '0;
    case (op)
      lmtc_pkg::OP_TICK: begin
        if (disp_on_q) begin
          acc = {1'b0, acc_q} + 9'(el);
          if (line_q >= lmtc_pkg::FirstVblankLine) begin
            if (mode_q != lmtc_pkg::MODE_VBLANK) begin
              if (stat_en_q[lmtc_pkg::EnVblankBit]) r.stat_irq = 1'b1;
              r.vblank_irq = 1'b1;
              mode_q = lmtc_pkg::MODE_VBLANK;
            end
            if (acc >= lmtc_pkg::LineCycles) begin
              acc = acc - lmtc_pkg::LineCycles;
              line_q = line_q + 8'd1;
              if (line_q > lmtc_pkg::LastLine) line_q = 8'd0;
              if (refresh_match()) r.stat_irq = 1'b1;
            end
          end else if (acc < lmtc_pkg::OamEnd) begin
            if (mode_q != lmtc_pkg::MODE_OAM) begin
              if (stat_en_q[lmtc_pkg::EnOamBit]) r.stat_irq = 1'b1;
              mode_q = lmtc_pkg::MODE_OAM;
            end
          end else if (acc < lmtc_pkg::DrawEnd) begin
            if (mode_q != lmtc_pkg::MODE_DRAW) begin
              mode_q = lmtc_pkg::MODE_DRAW;
              r.render_req = 1'b1;
            end
          end else if (acc < lmtc_pkg::LineCycles) begin
            if (mode_q != lmtc_pkg::MODE_HBLANK) begin
              if (stat_en_q[lmtc_pkg::EnHblankBit]) r.stat_irq = 1'b1;
              mode_q = lmtc_pkg::MODE_HBLANK;
            end
          end else begin
            line_q = line_q + 8'd1;
            if (refresh_match()) r.stat_irq = 1'b1;
            mode_q = lmtc_pkg::MODE_HBLANK;
            acc = acc - lmtc_pkg::LineCycles;
          end
          acc_q = acc[7:0];
        end
      end
      lmtc_pkg::OP_WR_STAT: stat_en_q = wd[7:3];
      lmtc_pkg::OP_WR_CTRL: begin
        disp_on_q = wd[lmtc_pkg::DisplayBit];
        if (!disp_on_q) begin
          mode_q = lmtc_pkg::MODE_VBLANK;
          line_q = 8'd0;
          acc_q  = 8'd0;
        end else if (refresh_match()) begin
          r.stat_irq = 1'b1;
        end
      end
      lmtc_pkg::OP_WR_LYC: begin
        lyc_q = wd;
        if (disp_on_q && refresh_match()) r.stat_irq = 1'b1;
      end
      lmtc_pkg::OP_RD_STAT: r.rdata = {stat_en_q, match_q, mode_q};
      lmtc_pkg::OP_RD_LINE: r.rdata = line_q;
      default: ;
    endcase
    r.cur_line = line_q;
    r.cur_mode = mode_q;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      acc_q     = 8'd0;
      line_q    = 8'd0;
      mode_q    = lmtc_pkg::MODE_HBLANK;
      disp_on_q = 1'b1;
      lyc_q     = 8'd0;
      stat_en_q = 5'd0;
      match_q   = 1'b0;
      pending_lcd_results.delete();
      fail_count <= 0;
      n_checked  <= 0;
      n_vblank   <= 0;
      n_render   <= 0;
      n_stat     <= 0;
    end else begin
      // results leave from the output register after their transfer in, so check before predicting
      if (out_valid && !out_stall) begin
        if (pending_lcd_results.size() == 0) begin
          $error("result with no expectation: line %0d mode %0d", out_cur_line, out_cur_mode);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_lcd_results.pop_front();
          n_checked <= n_checked + 1;
          n_vblank  <= n_vblank + int'(out_vblank_irq);
          n_render  <= n_render + int'(out_render_req);
          n_stat    <= n_stat + int'(out_stat_irq);
          if (out_rdata !== want.rdata || out_stat_irq !== want.stat_irq ||
              out_vblank_irq !== want.vblank_irq || out_render_req !== want.render_req ||
              out_cur_line !== want.cur_line || out_cur_mode !== want.cur_mode)
            fail_count <= fail_count + 1;
          if (out_rdata !== want.rdata)
            $error("rdata: expected %0d, got %0d", want.rdata, out_rdata);
          if (out_stat_irq !== want.stat_irq)
            $error("stat_irq: expected %0d, got %0d", want.stat_irq, out_stat_irq);
          if (out_vblank_irq !== want.vblank_irq)
            $error("vblank_irq: expected %0d, got %0d", want.vblank_irq, out_vblank_irq);
          if (out_render_req !== want.render_req)
            $error("render_req: expected %0d, got %0d", want.render_req, out_render_req);
          if (out_cur_line !== want.cur_line)
            $error("cur_line: expected %0d, got %0d", want.cur_line, out_cur_line);
          if (out_cur_mode !== want.cur_mode)
            $error("cur_mode: expected %0d, got %0d", want.cur_mode, out_cur_mode);
        end
      end
      if (in_valid && !in_stall)
        pending_lcd_results.push_back(lcd_timing_step(in_op, in_elapsed, in_wdata));
    end
    pending <= pending_lcd_results.size();
  end

endmodule

[bench/testbench.sv]
// Top of the LCD timing controller bench: clock, reset, bus stimulus, stall pattern, verdict.
module testbench;

  // cycles with no transfer on either channel before the run is declared hung;
  // the long receiver hold-off lasts HoldCycles, random stalls are far shorter
  localparam int IdleLimit  = 2000;
  localparam int HoldCycles = 300;
  localparam int PhaseItems = 350;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_op = 3'd0;
  logic [5:0] in_elapsed = 6'd0;
  logic [7:0] in_wdata = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_rdata;
  logic       out_stat_irq;
  logic       out_vblank_irq;
  logic       out_render_req;
  logic [7:0] out_cur_line;
  logic [1:0] out_cur_mode;

  int fail_count, pending, n_checked, n_vblank, n_render, n_stat;

  // idle percentages for each side; written only by the stimulus process
  int  send_idle = 0;
  int  recv_idle = 0;
  logic hold_go = 1'b0;

  // stall process bookkeeping
  logic hold_taken = 1'b0;
  int   hold_left = 0;

  int idle_cycles = 0;
  int n_sent = 0;

  lcd_mode_timing_controller uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_elapsed     (in_elapsed),
    .in_wdata       (in_wdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rdata      (out_rdata),
    .out_stat_irq   (out_stat_irq),
    .out_vblank_irq (out_vblank_irq),
    .out_render_req (out_render_req),
    .out_cur_line   (out_cur_line),
    .out_cur_mode   (out_cur_mode)
  );

  lmtc_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_elapsed     (in_elapsed),
    .in_wdata       (in_wdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rdata      (out_rdata),
    .out_stat_irq   (out_stat_irq),
    .out_vblank_irq (out_vblank_irq),
    .out_render_req (out_render_req),
    .out_cur_line   (out_cur_line),
    .out_cur_mode   (out_cur_mode),
    .fail_count     (fail_count),
    .pending        (pending),
    .n_checked      (n_checked),
    .n_vblank       (n_vblank),
    .n_render       (n_render),
    .n_stat         (n_stat)
  );

  always #4 clk = ~clk;

  // Receiver: random stall at the falling edge. Once hold_go rises, one long
  // hold-off runs so the output register fills and the input stalls behind it.
  always @(negedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // One bus transfer. Entered and left at a falling edge. Idle gaps only ever
  // drop valid; valid stays high across back-to-back transfers.
  task automatic bus_access(input logic [2:0] op, input logic [5:0] el, input logic [7:0] wd);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_elapsed <= el;
    in_wdata   <= wd;
    do @(posedge clk); while (in_stall);
    n_sent++;
    @(negedge clk);
  endtask

  // Random traffic: mostly ticks, biased toward long ones so the scan walks
  // through whole frames, plus register writes, reads and unused codes.
  task automatic random_access();
    int         pick;
    logic [7:0] wd;
    logic [5:0] el;
    pick = $urandom_range(99);
    wd   = 8'($urandom_range(255));
    el   = 6'($urandom_range(63));
    if (pick < 70) begin
      bus_access(lmtc_pkg::OP_TICK, 6'($urandom_range(63, 30)), wd);
    end else if (pick < 78) begin
      bus_access(lmtc_pkg::OP_TICK, el, wd);
    end else if (pick < 83) begin
      bus_access(lmtc_pkg::OP_WR_STAT, el, wd);
    end else if (pick < 88) begin
      // compare values mostly on real lines so matches happen as the scan passes
      if ($urandom_range(9) < 8) wd = 8'($urandom_range(153));
      bus_access(lmtc_pkg::OP_WR_LYC, el, wd);
    end else if (pick < 90) begin
      // display off is rare, it restarts the frame
      wd[lmtc_pkg::DisplayBit] = ($urandom_range(9) != 0);
      bus_access(lmtc_pkg::OP_WR_CTRL, el, wd);
    end else if (pick < 94) begin
      bus_access(lmtc_pkg::OP_RD_STAT, el, wd);
    end else if (pick < 98) begin
      bus_access(lmtc_pkg::OP_RD_LINE, el, wd);
    end else begin
      bus_access(3'($urandom_range(7, 6)), el, wd);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset reads, masked status write, compare match with and
    // without enable, mode entries, a tick that skips a mode, display off and
    // back on, compare write while off, unused codes.
    bus_access(lmtc_pkg::OP_RD_STAT, 6'd0, 8'h00);
    bus_access(lmtc_pkg::OP_RD_LINE, 6'd63, 8'hFF);
    bus_access(lmtc_pkg::OP_WR_LYC, 6'd0, 8'h00);
    bus_access(lmtc_pkg::OP_WR_STAT, 6'd0, 8'hFF);
    bus_access(lmtc_pkg::OP_RD_STAT, 6'd0, 8'h00);
    bus_access(lmtc_pkg::OP_WR_LYC, 6'd0, 8'h00);
    bus_access(lmtc_pkg::OP_TICK, 6'd0, 8'h00);
    bus_access(lmtc_pkg::OP_TICK, 6'd63, 8'h00);
    bus_access(lmtc_pkg::OP_TICK, 6'd63, 8'h00);
    bus_access(lmtc_pkg::OP_TICK, 6'd45, 8'h00);
    bus_access(lmtc_pkg::OP_TICK, 6'd20, 8'h00);
    bus_access(lmtc_pkg::OP_WR_CTRL, 6'd0, 8'h7F);
    bus_access(lmtc_pkg::OP_TICK, 6'd63, 8'h00);
    bus_access(lmtc_pkg::OP_RD_STAT, 6'd0, 8'h00);
    bus_access(lmtc_pkg::OP_WR_LYC, 6'd0, 8'hFF);
    bus_access(lmtc_pkg::OP_WR_CTRL, 6'd0, 8'h80);
    bus_access(3'd6, 6'd63, 8'hFF);
    bus_access(3'd7, 6'd0, 8'h00);
    bus_access(lmtc_pkg::OP_WR_STAT, 6'd0, 8'h00);
    bus_access(lmtc_pkg::OP_WR_LYC, 6'd0, 8'h05);
    bus_access(lmtc_pkg::OP_TICK, 6'd42, 8'hAA);
    bus_access(lmtc_pkg::OP_RD_LINE, 6'd21, 8'h55);

    // sender idles lightly, receiver heavily
    send_idle = 25;
    recv_idle = 66;
    repeat (PhaseItems) random_access();

    // the other way round
    send_idle = 66;
    recv_idle = 25;
    repeat (PhaseItems) random_access();

    // no idling; the long hold-off lands here while the sender keeps offering
    send_idle = 0;
    recv_idle = 0;
    hold_go <= 1'b1;
    repeat (PhaseItems) random_access();

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Run covered %0d bus transfers under three idle profiles, %0d results checked.",
             n_sent, n_checked);
    $display("Seen along the way: %0d vblank entries, %0d render requests, %0d status irqs.",
             n_vblank, n_render, n_stat);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/lmtc_pkg.sv
src/lcd_mode_timing_controller.sv
bench/lmtc_checker.sv
bench/testbench.sv
